@@ rtl/tmr_pkg.sv @@
// Package for the countdown timer: phase codes, action codes, register indexes,
// the configuration, state and result structs. No dependencies.
package tmr_pkg;

    typedef enum logic [1:0] {
        PH_SETUP = 2'd0,
        PH_RUN   = 2'd1,
        PH_PAUSE = 2'd2,
        PH_DONE  = 2'd3
    } phase_t;

    localparam logic [3:0] ACT_TICK       = 4'd0;
    localparam logic [3:0] ACT_FIELD_PREV = 4'd1;
    localparam logic [3:0] ACT_FIELD_NEXT = 4'd2;
    localparam logic [3:0] ACT_DIGIT      = 4'd3;
    localparam logic [3:0] ACT_UP         = 4'd4;
    localparam logic [3:0] ACT_DOWN       = 4'd5;
    localparam logic [3:0] ACT_START      = 4'd6;
    localparam logic [3:0] ACT_RESET      = 4'd7;
    localparam logic [3:0] ACT_DISMISS    = 4'd8;

    localparam logic [1:0] REG_BEEP_LENGTH = 2'd0;
    localparam logic [1:0] REG_SHORT_GAP   = 2'd1;
    localparam logic [1:0] REG_LONG_REST   = 2'd2;
    localparam logic [1:0] REG_ALARM_LIMIT = 2'd3;

    localparam int ADDR_W = 4;

    localparam logic [1:0] FIELD_HOURS   = 2'd0;
    localparam logic [1:0] FIELD_MINUTES = 2'd1;

    localparam logic [6:0]  HOURS_TOP   = 7'd99;
    localparam logic [6:0]  MS_TOP      = 7'd59;
    localparam logic [6:0]  MS_WRAP     = 7'd60;
    localparam logic [9:0]  MILLI_TOP   = 10'd999;
    localparam logic [15:0] AGE_TOP     = 16'hFFFF;

    typedef struct packed {
        logic [9:0]  beep_length_ms;
        logic [9:0]  short_gap_ms;
        logic [11:0] long_rest_ms;
        logic [15:0] alarm_limit_ms;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        beep_length_ms: 10'd120,
        short_gap_ms:   10'd100,
        long_rest_ms:   12'd500,
        alarm_limit_ms: 16'd30000
    };

    typedef struct packed {
        phase_t      phase;
        logic [6:0]  set_hours;
        logic [6:0]  set_minutes;
        logic [6:0]  set_seconds;
        logic [1:0]  edit_index;
        logic [9:0]  left_millis;
        logic [5:0]  left_seconds;
        logic [5:0]  left_minutes;
        logic [6:0]  left_hours;
        logic        alarm_on;
        logic [15:0] alarm_age;
        logic [12:0] alarm_wait;
        logic [1:0]  alarm_stage;
        logic [9:0]  beep_left;
    } timer_state_t;

    localparam timer_state_t STATE_RESET = '{
        phase:        PH_SETUP,
        set_hours:    7'd0,
        set_minutes:  7'd5,
        set_seconds:  7'd0,
        edit_index:   2'd0,
        left_millis:  10'd0,
        left_seconds: 6'd0,
        left_minutes: 6'd0,
        left_hours:   7'd0,
        alarm_on:     1'b0,
        alarm_age:    16'd0,
        alarm_wait:   13'd0,
        alarm_stage:  2'd0,
        beep_left:    10'd0
    };

    typedef struct packed {
        logic        just_expired;
        logic        ringing;
        logic        tone_on;
        logic [1:0]  selected_field;
        logic [6:0]  shown_seconds;
        logic [6:0]  shown_minutes;
        logic [6:0]  shown_hours;
        logic [1:0]  phase_now;
    } result_t;

endpackage

@@ rtl/tmr_regs.sv @@
// APB configuration registers of the countdown timer (alarm pattern timing).
// Depends on tmr_pkg.
module tmr_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tmr_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    output tmr_pkg::cfg_t                cfg
);

    tmr_pkg::cfg_t cfg_reg;
    tmr_pkg::cfg_t cfg_next;
    logic          wr_en;
    logic [1:0]    reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_idx = paddr[3:2];
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                tmr_pkg::REG_BEEP_LENGTH: cfg_next.beep_length_ms = pwdata[9:0];
                tmr_pkg::REG_SHORT_GAP:   cfg_next.short_gap_ms   = pwdata[9:0];
                tmr_pkg::REG_LONG_REST:   cfg_next.long_rest_ms   = pwdata[11:0];
                tmr_pkg::REG_ALARM_LIMIT: cfg_next.alarm_limit_ms = pwdata[15:0];
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= tmr_pkg::CFG_RESET;
        else
            cfg_reg <= cfg_next;
    end

    always_comb
    begin
        case (reg_idx)
            tmr_pkg::REG_BEEP_LENGTH: prdata = {22'd0, cfg_reg.beep_length_ms};
            tmr_pkg::REG_SHORT_GAP:   prdata = {22'd0, cfg_reg.short_gap_ms};
            tmr_pkg::REG_LONG_REST:   prdata = {20'd0, cfg_reg.long_rest_ms};
            tmr_pkg::REG_ALARM_LIMIT: prdata = {16'd0, cfg_reg.alarm_limit_ms};
            default:                  prdata = 32'd0;
        endcase
    end

endmodule

@@ rtl/tmr_core.sv @@
// Timer state and its update for one item: editing, start/pause,
// cascaded ms/s/m/h countdown and the alarm sequencer. Depends on tmr_pkg.
module tmr_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  logic [3:0]        action,
    input  logic [3:0]        key_digit,
    input  tmr_pkg::cfg_t     cfg,
    output tmr_pkg::result_t  result
);

    tmr_pkg::timer_state_t state_reg;
    tmr_pkg::timer_state_t state_next;

    // start normalization, from the current set values
    logic       carry_s;
    logic       carry_m;
    logic [6:0] norm_s;
    logic [7:0] sum_m;
    logic [6:0] norm_m;
    logic [7:0] sum_h;
    logic [6:0] norm_h;
    logic       start_nz;

    // edit helpers
    logic [6:0]  cur_val;
    logic [6:0]  cur_top;
    logic [14:0] div_prod;
    logic [3:0]  cur_quot;
    logic [6:0]  cur_rem;
    logic [6:0]  digit_val;
    logic [6:0]  up_val;
    logic [6:0]  dec_val;
    logic [6:0]  down_val;
    logic [6:0]  edit_val;
    logic        edit_wr;
    logic        left_nz;
    logic        expired;

    always_comb
    begin
        carry_s  = state_reg.set_seconds > tmr_pkg::MS_TOP;
        norm_s   = carry_s ? state_reg.set_seconds - tmr_pkg::MS_WRAP : state_reg.set_seconds;
        sum_m    = {1'b0, state_reg.set_minutes} + {7'd0, carry_s};
        carry_m  = sum_m > {1'b0, tmr_pkg::MS_TOP};
        norm_m   = carry_m ? sum_m[6:0] - tmr_pkg::MS_WRAP : sum_m[6:0];
        sum_h    = {1'b0, state_reg.set_hours} + {7'd0, carry_m};
        norm_h   = (sum_h > {1'b0, tmr_pkg::HOURS_TOP}) ? tmr_pkg::HOURS_TOP : sum_h[6:0];
        start_nz = (norm_h != 7'd0) || (norm_m != 7'd0) || (norm_s != 7'd0);
    end

    always_comb
    begin
        case (state_reg.edit_index)
            tmr_pkg::FIELD_HOURS:   cur_val = state_reg.set_hours;
            tmr_pkg::FIELD_MINUTES: cur_val = state_reg.set_minutes;
            default:                cur_val = state_reg.set_seconds;
        endcase
        cur_top   = (state_reg.edit_index == tmr_pkg::FIELD_HOURS) ?
                    tmr_pkg::HOURS_TOP : tmr_pkg::MS_TOP;
        // divide by ten through a reciprocal, exact for 7-bit values
        div_prod  = {8'd0, cur_val} * 15'd205;
        cur_quot  = div_prod[14:11];
        cur_rem   = cur_val - 7'({cur_quot, 3'd0} + {2'd0, cur_quot, 1'b0});
        digit_val = 7'({cur_rem[3:0], 3'd0} + {2'd0, cur_rem[3:0], 1'b0}) + {3'd0, key_digit};
        up_val    = (cur_val >= cur_top) ? cur_top : cur_val + 7'd1;
        dec_val   = cur_val - 7'd1;
        down_val  = (cur_val == 7'd0) ? 7'd0 : ((dec_val > cur_top) ? cur_top : dec_val);
    end

    assign left_nz = (state_reg.left_millis != 10'd0) || (state_reg.left_seconds != 6'd0) ||
                     (state_reg.left_minutes != 6'd0) || (state_reg.left_hours != 7'd0);

    always_comb
    begin
        state_next = state_reg;
        expired    = 1'b0;
        edit_wr    = 1'b0;
        edit_val   = cur_val;

        if (action == tmr_pkg::ACT_TICK)
        begin
            if (state_next.alarm_on)
            begin
                if (state_next.alarm_age != tmr_pkg::AGE_TOP)
                    state_next.alarm_age = state_next.alarm_age + 16'd1;
                if (state_next.alarm_wait != 13'd0)
                    state_next.alarm_wait = state_next.alarm_wait - 13'd1;
                if (state_next.beep_left != 10'd0)
                    state_next.beep_left = state_next.beep_left - 10'd1;
            end
            if (state_reg.phase == tmr_pkg::PH_RUN)
            begin
                if (state_reg.left_millis != 10'd0)
                    state_next.left_millis = state_reg.left_millis - 10'd1;
                else if (state_reg.left_seconds != 6'd0)
                begin
                    state_next.left_seconds = state_reg.left_seconds - 6'd1;
                    state_next.left_millis  = tmr_pkg::MILLI_TOP;
                end
                else if (state_reg.left_minutes != 6'd0)
                begin
                    state_next.left_minutes = state_reg.left_minutes - 6'd1;
                    state_next.left_seconds = tmr_pkg::MS_TOP[5:0];
                    state_next.left_millis  = tmr_pkg::MILLI_TOP;
                end
                else if (state_reg.left_hours != 7'd0)
                begin
                    state_next.left_hours   = state_reg.left_hours - 7'd1;
                    state_next.left_minutes = tmr_pkg::MS_TOP[5:0];
                    state_next.left_seconds = tmr_pkg::MS_TOP[5:0];
                    state_next.left_millis  = tmr_pkg::MILLI_TOP;
                end
                if ((state_next.left_millis == 10'd0) && (state_next.left_seconds == 6'd0) &&
                    (state_next.left_minutes == 6'd0) && (state_next.left_hours == 7'd0))
                begin
                    state_next.phase = tmr_pkg::PH_DONE;
                    if (!state_next.alarm_on)
                    begin
                        state_next.alarm_on    = 1'b1;
                        state_next.alarm_age   = 16'd0;
                        state_next.alarm_wait  = 13'd0;
                        state_next.alarm_stage = 2'd0;
                    end
                    expired = 1'b1;
                end
            end
            if (state_next.alarm_on)
            begin
                if (state_next.alarm_age >= cfg.alarm_limit_ms)
                begin
                    state_next.alarm_on    = 1'b0;
                    state_next.alarm_stage = 2'd0;
                    state_next.beep_left   = 10'd0;
                end
                else if (state_next.alarm_wait == 13'd0)
                begin
                    case (state_next.alarm_stage)
                        2'd0:
                        begin
                            state_next.beep_left   = cfg.beep_length_ms;
                            state_next.alarm_wait  = {3'd0, cfg.beep_length_ms} +
                                                     {3'd0, cfg.short_gap_ms};
                            state_next.alarm_stage = 2'd1;
                        end
                        2'd1:
                        begin
                            state_next.beep_left   = cfg.beep_length_ms;
                            state_next.alarm_wait  = {3'd0, cfg.beep_length_ms} +
                                                     {1'b0, cfg.long_rest_ms};
                            state_next.alarm_stage = 2'd2;
                        end
                        default:
                        begin
                            state_next.alarm_stage = 2'd0;
                            state_next.alarm_wait  = 13'd0;
                        end
                    endcase
                end
            end
        end
        else
        begin
            // go to setup on reset (or dismiss when done); start pauses a run, resumes a pause, else starts
            if (((state_reg.phase == tmr_pkg::PH_DONE) &&
                 ((action == tmr_pkg::ACT_DISMISS) || (action == tmr_pkg::ACT_RESET))) ||
                ((state_reg.phase != tmr_pkg::PH_DONE) && (action == tmr_pkg::ACT_RESET)))
            begin
                state_next.alarm_on     = 1'b0;
                state_next.alarm_stage  = 2'd0;
                state_next.beep_left    = 10'd0;
                state_next.phase        = tmr_pkg::PH_SETUP;
                state_next.edit_index   = 2'd0;
                state_next.left_millis  = 10'd0;
                state_next.left_seconds = 6'd0;
                state_next.left_minutes = 6'd0;
                state_next.left_hours   = 7'd0;
            end
            else if (action == tmr_pkg::ACT_START)
            begin
                case (state_reg.phase)
                    tmr_pkg::PH_RUN:   state_next.phase = tmr_pkg::PH_PAUSE;
                    tmr_pkg::PH_PAUSE:
                    begin
                        if (left_nz)
                            state_next.phase = tmr_pkg::PH_RUN;
                    end
                    default:
                    begin
                        if (state_reg.phase == tmr_pkg::PH_DONE)
                        begin
                            state_next.alarm_on    = 1'b0;
                            state_next.alarm_stage = 2'd0;
                            state_next.beep_left   = 10'd0;
                        end
                        state_next.set_hours   = norm_h;
                        state_next.set_minutes = norm_m;
                        state_next.set_seconds = norm_s;
                        if (start_nz)
                        begin
                            state_next.left_millis  = 10'd0;
                            state_next.left_seconds = norm_s[5:0];
                            state_next.left_minutes = norm_m[5:0];
                            state_next.left_hours   = norm_h;
                            state_next.phase        = tmr_pkg::PH_RUN;
                        end
                    end
                endcase
            end
            else if (state_reg.phase == tmr_pkg::PH_SETUP)
            begin
                case (action)
                    tmr_pkg::ACT_FIELD_PREV:
                    begin
                        case (state_reg.edit_index)
                            2'd0:    state_next.edit_index = 2'd2;
                            2'd1:    state_next.edit_index = 2'd0;
                            default: state_next.edit_index = 2'd1;
                        endcase
                    end
                    tmr_pkg::ACT_FIELD_NEXT:
                    begin
                        case (state_reg.edit_index)
                            2'd0:    state_next.edit_index = 2'd1;
                            2'd1:    state_next.edit_index = 2'd2;
                            default: state_next.edit_index = 2'd0;
                        endcase
                    end
                    tmr_pkg::ACT_DIGIT:
                    begin
                        edit_wr  = key_digit <= 4'd9;
                        edit_val = digit_val;
                    end
                    tmr_pkg::ACT_UP:
                    begin
                        edit_wr  = 1'b1;
                        edit_val = up_val;
                    end
                    tmr_pkg::ACT_DOWN:
                    begin
                        edit_wr  = 1'b1;
                        edit_val = down_val;
                    end
                    default:
                    begin
                        edit_wr = 1'b0;
                    end
                endcase
                if (edit_wr)
                begin
                    case (state_reg.edit_index)
                        tmr_pkg::FIELD_HOURS:   state_next.set_hours   = edit_val;
                        tmr_pkg::FIELD_MINUTES: state_next.set_minutes = edit_val;
                        default:                state_next.set_seconds = edit_val;
                    endcase
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= tmr_pkg::STATE_RESET;
        else if (fire)
            state_reg <= state_next;
    end

    always_comb
    begin
        result.phase_now = state_next.phase;
        if (state_next.phase == tmr_pkg::PH_SETUP)
        begin
            result.shown_hours   = state_next.set_hours;
            result.shown_minutes = state_next.set_minutes;
            result.shown_seconds = state_next.set_seconds;
        end
        else
        begin
            result.shown_hours   = state_next.left_hours;
            result.shown_minutes = {1'b0, state_next.left_minutes};
            result.shown_seconds = {1'b0, state_next.left_seconds};
        end
        result.selected_field = state_next.edit_index;
        result.tone_on        = state_next.beep_left != 10'd0;
        result.ringing        = state_next.alarm_on;
        result.just_expired   = expired;
    end

endmodule

@@ rtl/countdown_timer_with_alarm.sv @@
// Top level of the HH:MM:SS countdown timer with alarm: input register, timer
// core, result register and APB registers. Depends on tmr_pkg, tmr_regs, tmr_core.
//
//   channel   | direction | payload
//   s_axis    | in        | tdata[3:0] action, tdata[7:4] key_digit
//   m_axis    | out       | tdata[27:0] result fields, [31:28] zero
//   apb       | in/out    | 4 timing registers at byte offsets 0, 4, 8, 12
//
// One item per cycle while the output is not stalled; an item's result passes through
// the input register, then the core update into the result register.
// The input register accepts a new item while a result waits downstream, if it holds none.
// Reset is asynchronous, active low; no clearing pass is needed.
module countdown_timer_with_alarm (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [7:0]                  s_axis_tdata,  // [3:0] action, [7:4] key_digit
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // [1:0] phase_now, [8:2] shown_hours, [15:9] shown_minutes, [22:16] shown_seconds,
    // [24:23] selected_field, [25] tone_on, [26] ringing, [27] just_expired
    output logic [31:0]                 m_axis_tdata,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tmr_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    tmr_pkg::cfg_t    cfg;
    tmr_pkg::result_t core_result;

    logic             in_valid_reg;
    logic             in_valid_next;
    logic [3:0]       in_action_reg;
    logic [3:0]       in_digit_reg;
    logic             out_valid_reg;
    logic             out_valid_next;
    tmr_pkg::result_t out_data_reg;
    logic             advance;
    logic             s_fire;

    assign advance       = in_valid_reg & (~out_valid_reg | m_axis_tready);
    assign s_axis_tready = ~in_valid_reg | advance;
    assign s_fire        = s_axis_tvalid & s_axis_tready;

    assign in_valid_next  = s_fire | (in_valid_reg & ~advance);
    assign out_valid_next = advance | (out_valid_reg & ~m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            in_action_reg <= s_axis_tdata[3:0];
            in_digit_reg  <= s_axis_tdata[7:4];
        end
        if (advance)
            out_data_reg <= core_result;
    end

    tmr_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tmr_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (advance),
        .action    (in_action_reg),
        .key_digit (in_digit_reg),
        .cfg       (cfg),
        .result    (core_result)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'd0, out_data_reg};

endmodule

@@ rtl/tmr_checker.sv @@
// Port-level checker for the countdown timer, bound to the top level.
// Depends on the m_axis port layout of countdown_timer_with_alarm.
module tmr_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata
);

    localparam logic [1:0] PHASE_DONE = 2'd3;

    logic [1:0] phase_now;
    logic [1:0] selected_field;

    assign phase_now      = m_axis_tdata[1:0];
    assign selected_field = m_axis_tdata[24:23];

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_tone_needs_ring: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[25] |-> m_axis_tdata[26])
        else $error("tone on without alarm");

    a_expired_done: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[27] |-> phase_now == PHASE_DONE)
        else $error("expiry outside finished phase");

    a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && phase_now == PHASE_DONE |-> m_axis_tdata[22:2] == 21'd0)
        else $error("finished with time left");

    a_field_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> selected_field != 2'd3)
        else $error("selected field out of range");

endmodule

bind countdown_timer_with_alarm tmr_checker u_tmr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
